// ----- sv/tdds_pkg.sv -----
// Package for the timed differential-drive sequencer.
// Holds the beat layouts, command and move codes, and the side-drive helpers.
// No dependencies; imported by timed_differential_drive_sequencer_core.
package tdds_pkg;

    // Field widths of the input beat.
    localparam int FUNC_W  = 3;
    localparam int MOVE_W  = 5;
    localparam int SPEED_W = 8;
    localparam int DURATION_BITS = 16;

    // Field widths of the result beat.
    localparam int DUTY_W  = 8;

    // Beat widths (input fields pack to exactly four bytes; results pad to five).
    localparam int IN_W    = FUNC_W + MOVE_W + SPEED_W + DURATION_BITS;
    localparam int OUT_RAW = 4 * DUTY_W + MOVE_W + 2;
    localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

    // Configuration registers.
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 10;
    localparam int HALF_W    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_SPEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIGGLE_HALF   = 1'b1;

    localparam logic [SPEED_W-1:0] DEFAULT_SPEED_RESET = 8'd150;
    localparam logic [HALF_W-1:0]  WIGGLE_HALF_RESET   = 10'd150;

    // Command codes carried in the func field.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK       = 3'd0,
        FUNC_DRIVE      = 3'd1,
        FUNC_DRIVE_TIME = 3'd2,
        FUNC_STOP       = 3'd3,
        FUNC_LOCK       = 3'd4,
        FUNC_UNLOCK     = 3'd5
    } func_t;

    // Move codes.
    localparam logic [MOVE_W-1:0] MOVE_STOP        = 5'd0;
    localparam logic [MOVE_W-1:0] MOVE_FWD         = 5'd1;
    localparam logic [MOVE_W-1:0] MOVE_BACK        = 5'd2;
    localparam logic [MOVE_W-1:0] MOVE_PIVOT_L     = 5'd3;
    localparam logic [MOVE_W-1:0] MOVE_PIVOT_R     = 5'd4;
    localparam logic [MOVE_W-1:0] MOVE_TURN_L      = 5'd5;
    localparam logic [MOVE_W-1:0] MOVE_TURN_R      = 5'd6;
    localparam logic [MOVE_W-1:0] MOVE_CURVE_L     = 5'd7;
    localparam logic [MOVE_W-1:0] MOVE_CURVE_R     = 5'd8;
    localparam logic [MOVE_W-1:0] MOVE_WIGGLE      = 5'd9;
    localparam logic [MOVE_W-1:0] MOVE_DONUT       = 5'd10;
    localparam logic [MOVE_W-1:0] MOVE_HOP         = 5'd11;
    localparam logic [MOVE_W-1:0] MOVE_FLINCH      = 5'd12;
    localparam logic [MOVE_W-1:0] MOVE_JERK        = 5'd13;
    localparam logic [MOVE_W-1:0] MOVE_SLOW_FWD    = 5'd14;
    localparam logic [MOVE_W-1:0] MOVE_SLOW_CURVE  = 5'd15;
    localparam logic [MOVE_W-1:0] MOVE_SLOW_REV    = 5'd16;
    localparam logic [MOVE_W-1:0] MOVE_LAST        = MOVE_SLOW_REV;

    // Fixed speeds, boosts and caps of the special moves.
    localparam logic [DUTY_W-1:0] DONUT_CAP   = 8'd240;
    localparam logic [DUTY_W:0]   DUTY_CAP    = 9'd255;
    localparam logic [DUTY_W-1:0] BOOST_SMALL = 8'd35;
    localparam logic [DUTY_W-1:0] BOOST_LARGE = 8'd50;
    localparam logic [DUTY_W-1:0] JERK_SPEED  = 8'd200;
    localparam logic [DUTY_W-1:0] SLOW_SPEED  = 8'd110;
    localparam logic [DUTY_W-1:0] SLOW_OUTER  = 8'd140;
    localparam logic [DUTY_W-1:0] SLOW_INNER  = 8'd65;

    // Reciprocal of five in 10-bit fixed point; exact for dividends below 1024.
    localparam logic [7:0] RECIP_FIVE = 8'd205;

    // One motor side: direction and magnitude.
    typedef struct packed {
        logic              rev;
        logic [DUTY_W-1:0] mag;
    } side_t;

    function automatic side_t side_fwd(input logic [DUTY_W-1:0] mag);
        side_t s;
        s.rev = 1'b0;
        s.mag = mag;
        return s;
    endfunction

    function automatic side_t side_rev(input logic [DUTY_W-1:0] mag);
        side_t s;
        s.rev = 1'b1;
        s.mag = mag;
        return s;
    endfunction

    // Forward and reverse duties of one side.
    function automatic logic [DUTY_W-1:0] fwd_duty(input side_t s);
        return s.rev ? '0 : s.mag;
    endfunction

    function automatic logic [DUTY_W-1:0] back_duty(input side_t s);
        return s.rev ? s.mag : '0;
    endfunction

endpackage

// ----- sv/timed_differential_drive_sequencer_core.sv -----
// Timed differential-drive sequencer: move commands and ticks to four H-bridge duties.
// Depends on tdds_pkg for beat layouts, codes and side-drive helpers.
//
//  Channel  | Direction | Handshake                 | Content
//  ---------+-----------+---------------------------+------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready      | func, move, speed, duration_ms
//  m_axis   | out       | m_axis_tvalid/tready      | four duties, move_now, flags
//  cfg      | in        | cfg_valid/cfg_ready       | register index and write data
//
// Each command or tick beat is registered, then combinational logic updates the
// state and result registers, so one beat is taken every cycle unless the result stalls.
// The state registers double as the result register; a stalled result holds them.
// rst_n resets all registers but the input data fields asynchronously, to their reset values.
// The input stage keeps taking beats while the result is waiting, one deep.
module timed_differential_drive_sequencer_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [2:0] func, [7:3] move, [15:8] speed, [31:16] duration_ms
    input  logic [tdds_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] left_fwd_duty, [15:8] left_back_duty, [23:16] right_fwd_duty,
    // [31:24] right_back_duty, [36:32] move_now, [37] is_locked,
    // [38] timed_running, [39] zero
    output logic [tdds_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [tdds_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tdds_pkg::CFG_W-1:0]   cfg_data
);
    import tdds_pkg::*;

    // Configuration registers.
    logic [SPEED_W-1:0]        default_speed_reg;
    logic [HALF_W-1:0]         half_period_reg;

    // Input stage.
    logic                      in_valid_reg;
    logic [FUNC_W-1:0]         in_func_reg;
    logic [MOVE_W-1:0]         in_move_reg;
    logic [SPEED_W-1:0]        in_speed_reg;
    logic [DURATION_BITS-1:0]  in_dur_reg;

    // Sequencer state.
    logic                      out_valid_reg;
    logic [MOVE_W-1:0]         move_reg,     move_next;
    logic [SPEED_W-1:0]        speed_reg,    speed_next;
    logic                      lock_reg,     lock_next;
    logic                      timed_reg,    timed_next;
    logic [DURATION_BITS-1:0]  elapsed_reg,  elapsed_next;
    logic [DURATION_BITS-1:0]  duration_reg, duration_next;
    logic [HALF_W-1:0]         wcount_reg,   wcount_next;
    logic                      phase_reg,    phase_next;
    logic [DUTY_W-1:0]         lf_reg, lf_next;
    logic [DUTY_W-1:0]         lb_reg, lb_next;
    logic [DUTY_W-1:0]         rf_reg, rf_next;
    logic [DUTY_W-1:0]         rb_reg, rb_next;

    // Datapath.
    logic                      proc_fire;
    logic [MOVE_W-1:0]         mv_sel;
    logic [SPEED_W-1:0]        s_eff;
    logic [11:0]               s_x9;
    logic [9:0]                s_x9_q;
    logic [17:0]               curve_prod;
    logic [DUTY_W-1:0]         curve_spd;
    logic [DUTY_W:0]           boost35;
    logic [DUTY_W:0]           boost50;
    logic [DUTY_W-1:0]         donut_spd;
    logic [DUTY_W-1:0]         hop_spd;
    logic [DUTY_W-1:0]         flinch_spd;
    side_t                     cmd_left, cmd_right;
    side_t                     wig_left, wig_right;
    side_t                     ld_left,  ld_right;
    logic                      load_sides;
    logic                      do_stop;
    logic [DURATION_BITS-1:0]  elapsed_inc;
    logic [HALF_W-1:0]         wcount_inc;
    logic                      wcount_wrap;
    logic                      phase_tick;
    logic [DUTY_W-1:0]         half_spd;

    // Handshakes: the input stage drains whenever the result slot is free.
    assign proc_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;

    // Result beat straight from the state registers.
    assign m_axis_tdata = {{(OUT_W - OUT_RAW){1'b0}}, timed_reg, lock_reg, move_reg,
                           rb_reg, rf_reg, lb_reg, lf_reg};

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_speed_reg <= DEFAULT_SPEED_RESET;
            half_period_reg   <= WIGGLE_HALF_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEFAULT_SPEED: default_speed_reg <= cfg_data[SPEED_W-1:0];
                CFG_WIGGLE_HALF:   half_period_reg   <= cfg_data[HALF_W-1:0];
                default:           ;
            endcase
        end
    end

    // Input register stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_func_reg  <= s_axis_tdata[FUNC_W-1:0];
            in_move_reg  <= s_axis_tdata[FUNC_W +: MOVE_W];
            in_speed_reg <= s_axis_tdata[FUNC_W+MOVE_W +: SPEED_W];
            in_dur_reg   <= s_axis_tdata[FUNC_W+MOVE_W+SPEED_W +: DURATION_BITS];
        end
    end

    // Move code, with out-of-range codes selecting stop, and commanded speed, with zero selecting the default speed.
    assign mv_sel = (in_move_reg > MOVE_LAST) ? MOVE_STOP : in_move_reg;
    assign s_eff  = (in_speed_reg == '0) ? default_speed_reg : in_speed_reg;

    // Curve inner speed: s*45/100 = ((s*9)/4)/5, the last step by reciprocal.
    assign s_x9       = {1'b0, s_eff, 3'b000} + {4'b0000, s_eff};
    assign s_x9_q     = s_x9[11:2];
    assign curve_prod = {8'd0, s_x9_q} * {10'd0, RECIP_FIVE};
    assign curve_spd  = curve_prod[17:10];

    // Boosted speeds with their caps.
    assign boost35    = {1'b0, s_eff} + {1'b0, BOOST_SMALL};
    assign boost50    = {1'b0, s_eff} + {1'b0, BOOST_LARGE};
    assign donut_spd  = (boost35 > {1'b0, DONUT_CAP}) ? DONUT_CAP : boost35[DUTY_W-1:0];
    assign hop_spd    = (boost35 > DUTY_CAP) ? DUTY_CAP[DUTY_W-1:0] : boost35[DUTY_W-1:0];
    assign flinch_spd = (boost50 > DUTY_CAP) ? DUTY_CAP[DUTY_W-1:0] : boost50[DUTY_W-1:0];

    // Side drives of a new move command.
    always_comb
    begin
        cmd_left  = side_fwd('0);
        cmd_right = side_fwd('0);
        unique case (mv_sel)
            MOVE_FWD:        begin cmd_left = side_fwd(s_eff);      cmd_right = side_fwd(s_eff);      end
            MOVE_BACK:       begin cmd_left = side_rev(s_eff);      cmd_right = side_rev(s_eff);      end
            MOVE_PIVOT_L:    begin cmd_left = side_rev(s_eff);      cmd_right = side_fwd(s_eff);      end
            MOVE_PIVOT_R:    begin cmd_left = side_fwd(s_eff);      cmd_right = side_rev(s_eff);      end
            MOVE_TURN_L:     begin cmd_left = side_fwd('0);         cmd_right = side_fwd(s_eff);      end
            MOVE_TURN_R:     begin cmd_left = side_fwd(s_eff);      cmd_right = side_fwd('0);         end
            MOVE_CURVE_L:    begin cmd_left = side_fwd(curve_spd);  cmd_right = side_fwd(s_eff);      end
            MOVE_CURVE_R:    begin cmd_left = side_fwd(s_eff);      cmd_right = side_fwd(curve_spd);  end
            MOVE_WIGGLE:     begin cmd_left = side_fwd(s_eff);      cmd_right = side_rev(s_eff);      end
            MOVE_DONUT:      begin cmd_left = side_fwd(donut_spd);  cmd_right = side_rev(donut_spd);  end
            MOVE_HOP:        begin cmd_left = side_fwd(hop_spd);    cmd_right = side_fwd(hop_spd);    end
            MOVE_FLINCH:     begin cmd_left = side_rev(flinch_spd); cmd_right = side_rev(flinch_spd); end
            MOVE_JERK:       begin cmd_left = side_fwd(JERK_SPEED); cmd_right = side_fwd(JERK_SPEED); end
            MOVE_SLOW_FWD:   begin cmd_left = side_fwd(SLOW_SPEED); cmd_right = side_fwd(SLOW_SPEED); end
            MOVE_SLOW_CURVE: begin cmd_left = side_fwd(SLOW_OUTER); cmd_right = side_fwd(SLOW_INNER); end
            MOVE_SLOW_REV:   begin cmd_left = side_rev(SLOW_OUTER); cmd_right = side_rev(SLOW_INNER); end
            default:         ;
        endcase
    end

    // Tick arithmetic: saturating elapsed count and the wiggle half-period counter.
    assign elapsed_inc = (elapsed_reg != '1) ? (elapsed_reg + 1'b1) : elapsed_reg;
    assign wcount_inc  = wcount_reg + 1'b1;
    assign wcount_wrap = (wcount_inc >= half_period_reg);
    assign phase_tick  = phase_reg ^ wcount_wrap;
    assign half_spd    = {1'b0, speed_reg[SPEED_W-1:1]};
    assign wig_left    = phase_tick ? side_fwd(half_spd) : side_rev(half_spd);
    assign wig_right   = phase_tick ? side_rev(half_spd) : side_fwd(half_spd);

    // Next state for the beat in the input stage.
    always_comb
    begin
        move_next     = move_reg;
        speed_next    = speed_reg;
        lock_next     = lock_reg;
        timed_next    = timed_reg;
        elapsed_next  = elapsed_reg;
        duration_next = duration_reg;
        wcount_next   = wcount_reg;
        phase_next    = phase_reg;
        load_sides    = 1'b0;
        ld_left       = cmd_left;
        ld_right      = cmd_right;
        do_stop       = 1'b0;

        if (proc_fire)
        begin
            unique case (in_func_reg)
                FUNC_TICK:
                begin
                    if (lock_reg)
                        do_stop = (move_reg != MOVE_STOP);
                    else if (timed_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if (elapsed_inc >= duration_reg)
                            do_stop = 1'b1;
                        else if (move_reg == MOVE_WIGGLE)
                        begin
                            wcount_next = wcount_wrap ? '0 : wcount_inc;
                            phase_next  = phase_tick;
                            load_sides  = 1'b1;
                            ld_left     = wig_left;
                            ld_right    = wig_right;
                        end
                    end
                end
                FUNC_DRIVE, FUNC_DRIVE_TIME:
                begin
                    if (!lock_reg)
                    begin
                        move_next  = mv_sel;
                        speed_next = in_speed_reg;
                        load_sides = 1'b1;
                        timed_next = (in_func_reg == FUNC_DRIVE_TIME);
                        if (in_func_reg == FUNC_DRIVE_TIME)
                        begin
                            elapsed_next  = '0;
                            duration_next = in_dur_reg;
                            wcount_next   = '0;
                            phase_next    = 1'b0;
                        end
                    end
                end
                FUNC_STOP:
                    do_stop = 1'b1;
                FUNC_LOCK:
                begin
                    lock_next = 1'b1;
                    do_stop   = 1'b1;
                end
                FUNC_UNLOCK:
                    lock_next = 1'b0;
                default:
                    ;
            endcase
        end

        // Stop clears the move and all four duties.
        if (do_stop)
        begin
            timed_next = 1'b0;
            move_next  = MOVE_STOP;
            speed_next = '0;
            lf_next    = '0;
            lb_next    = '0;
            rf_next    = '0;
            rb_next    = '0;
        end
        else if (load_sides)
        begin
            lf_next = fwd_duty(ld_left);
            lb_next = back_duty(ld_left);
            rf_next = fwd_duty(ld_right);
            rb_next = back_duty(ld_right);
        end
        else
        begin
            lf_next = lf_reg;
            lb_next = lb_reg;
            rf_next = rf_reg;
            rb_next = rb_reg;
        end
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            move_reg      <= MOVE_STOP;
            speed_reg     <= '0;
            lock_reg      <= 1'b0;
            timed_reg     <= 1'b0;
            elapsed_reg   <= '0;
            duration_reg  <= '0;
            wcount_reg    <= '0;
            phase_reg     <= 1'b0;
            lf_reg        <= '0;
            lb_reg        <= '0;
            rf_reg        <= '0;
            rb_reg        <= '0;
        end
        else
        begin
            if (proc_fire)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            move_reg     <= move_next;
            speed_reg    <= speed_next;
            lock_reg     <= lock_next;
            timed_reg    <= timed_next;
            elapsed_reg  <= elapsed_next;
            duration_reg <= duration_next;
            wcount_reg   <= wcount_next;
            phase_reg    <= phase_next;
            lf_reg       <= lf_next;
            lb_reg       <= lb_next;
            rf_reg       <= rf_next;
            rb_reg       <= rb_next;
        end
    end

    // While locked the drive stays stopped.
    assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg |-> (move_reg == MOVE_STOP) && (lf_reg == '0) && (lb_reg == '0)
                     && (rf_reg == '0) && (rb_reg == '0))
        else $error("locked sequencer is driving the motors");

    // The stop move never drives a duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (move_reg == MOVE_STOP) |-> (lf_reg == '0) && (lb_reg == '0)
                                    && (rf_reg == '0) && (rb_reg == '0))
        else $error("stop move with a non-zero duty");

    // A bridge side is never driven both ways at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((lf_reg == '0) || (lb_reg == '0)) && ((rf_reg == '0) || (rb_reg == '0)))
        else $error("forward and reverse duty both active on one side");

    // A waiting result keeps the state untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> $stable(move_reg) && $stable(lock_reg)
            && $stable(timed_reg) && $stable(elapsed_reg) && $stable(lf_reg)
            && $stable(rb_reg))
        else $error("state changed while a result was stalled");

    // A zero half period makes the wiggle phase flip on every tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        (half_period_reg == '0) |-> wcount_wrap)
        else $error("wiggle counter failed to wrap with zero half period");

endmodule
